// ===== hdl/peak_lattice_signal_normalizer_macros.svh =====
// Assertion macros for the peak lattice signal normalizer.
// No dependencies.
`ifndef PEAK_LATTICE_SIGNAL_NORMALIZER_MACROS_SVH
`define PEAK_LATTICE_SIGNAL_NORMALIZER_MACROS_SVH

// implication checked every cycle outside reset
`define PLSN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLSN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/plsn_pkg.sv =====
// Package for the peak lattice signal normalizer: payload types, codes, sizes.
// No dependencies.
package plsn_pkg;
   localparam int MAX_PEAKS = 8;
   localparam int PIDX_W = $clog2(MAX_PEAKS);
   localparam int PCNT_W = $clog2(MAX_PEAKS + 1);
   localparam int QDEPTH = 2;
   localparam int DIV_STEPS = 51;  // quotient bits of the restoring divider
   localparam int DCNT_W = 6;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FEW   = 3'd1,
      ST_ORDER = 3'd2,
      ST_FULL  = 3'd3,
      ST_SAT   = 3'd4
   } status_type;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_NORM = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] value;
      logic        restart;
   } req_type;

   typedef struct packed {
      logic [31:0] normalized;
      logic [2:0]  status;
   } rsp_type;

   // front to back: either a finished result or a division job
   typedef struct packed {
      logic               divide;
      logic [31:0]        result;
      status_type         status;
      logic signed [50:0] num2;   // 2*num + gap
      logic [33:0]        den2;   // 2*gap, positive
      logic [PIDX_W-1:0]  k;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_FIX,
      BK_OUT
   } back_state_type;
endpackage

// ===== hdl/plsn_front.sv =====
// Front end: holds the peak table, handles loads, finds the bracket and
// prepares division jobs. Depends on plsn_pkg.
module plsn_front
   import plsn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] csr_failure_value,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        job_valid,
   input  logic        job_ready,
   output job_type     job_data
);
   logic [31:0]       peak_ff [MAX_PEAKS];
   logic [PCNT_W-1:0] npeaks_ff, npeaks_in;
   logic              busy_ff, busy_in;   // bracket stage holds a sample
   logic signed [31:0] samp_ff;
   logic [PIDX_W-1:0] k_ff, k_in;
   logic              out_valid_ff, out_valid_in;
   job_type           out_ff, out_in;
   logic              take, wr_en;
   logic [PCNT_W-1:0] base;
   logic signed [32:0] gap;
   logic signed [33:0] diff;

   assign req_ready = !busy_ff && (!out_valid_ff || job_ready);
   assign take = req_valid && req_ready;
   assign job_valid = out_valid_ff;
   assign job_data = out_ff;

   always_comb begin
      npeaks_in = npeaks_ff;
      busy_in = busy_ff;
      k_in = k_ff;
      out_valid_in = out_valid_ff && !job_ready;
      out_in = out_ff;
      wr_en = 1'b0;
      base = req_data.restart ? '0 : npeaks_ff;
      gap = 33'(signed'(peak_ff[k_ff + PIDX_W'(1)])) - 33'(signed'(peak_ff[k_ff]));
      diff = 34'(samp_ff) - 34'(signed'(peak_ff[k_ff]));
      if (take) begin
         out_in = '0;
         if (req_data.req_type == REQ_LOAD) begin
            out_valid_in = 1'b1;
            out_in.status = ST_OK;
            if (base == PCNT_W'(MAX_PEAKS)) begin
               out_in.status = ST_FULL;
               npeaks_in = base;
            end else if (base != '0 && signed'(req_data.value)
                         <= signed'(peak_ff[PIDX_W'(base - PCNT_W'(1))])) begin
               out_in.status = ST_ORDER;
               npeaks_in = base;
            end else begin
               wr_en = 1'b1;
               npeaks_in = base + PCNT_W'(1);
            end
         end else if (npeaks_ff < PCNT_W'(2)) begin
            out_valid_in = 1'b1;
            out_in.result = csr_failure_value;
            out_in.status = ST_FEW;
         end else begin
            busy_in = 1'b1;
            k_in = '0;
         end
      end else if (busy_ff) begin
         // one peak tested per cycle
         if (PCNT_W'(k_ff) + PCNT_W'(2) < npeaks_ff
             && samp_ff >= signed'(peak_ff[k_ff + PIDX_W'(1)])) begin
            k_in = k_ff + PIDX_W'(1);
         end else if (!out_valid_ff || job_ready) begin
            busy_in = 1'b0;
            out_valid_in = 1'b1;
            out_in = '0;
            out_in.divide = 1'b1;
            out_in.k = k_ff;
            out_in.num2 = 51'(signed'(diff)) <<< 17;
            out_in.num2 = out_in.num2 + 51'(gap);
            out_in.den2 = 34'(gap) << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         npeaks_ff <= '0;
         busy_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         npeaks_ff <= npeaks_in;
         busy_ff <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      k_ff <= k_in;
      out_ff <= out_in;
      if (take) samp_ff <= signed'(req_data.value);
      if (wr_en) peak_ff[PIDX_W'(base)] <= req_data.value;
   end
endmodule

// ===== hdl/plsn_queue.sv =====
// Short job queue between front and back end. Depends on plsn_pkg.
module plsn_queue
   import plsn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_data
);
   job_type slot_ff [QDEPTH];
   logic [0:0] wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != 2'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wp_ff] <= in_data;
   end
endmodule

// ===== hdl/plsn_back.sv =====
// Back end: serial floor divider, peak offset add, saturation, output
// register. Depends on plsn_pkg.
module plsn_back
   import plsn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   back_state_type     state_ff, state_in;
   logic               neg_ff;
   logic [50:0]        mag_ff;     // |num2|, shifted out as quotient builds
   logic [33:0]        den_ff;
   logic [33:0]        rem_ff;
   logic [50:0]        quo_ff;
   logic [DCNT_W-1:0]  cnt_ff;
   logic [PIDX_W-1:0]  k_ff;
   rsp_type            out_ff;
   logic [34:0]        trial;
   logic signed [51:0] q, r;

   assign job_ready = state_ff == BK_IDLE;
   assign rsp_valid = state_ff == BK_OUT;
   assign rsp_data = out_ff;
   assign trial = {rem_ff, mag_ff[50]} - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (job_valid) state_in = job_data.divide ? BK_DIV : BK_OUT;
         BK_DIV:  if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) state_in = BK_FIX;
         BK_FIX:  state_in = BK_OUT;
         BK_OUT:  if (rsp_ready) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      // floor: negative dividend with remainder rounds down one more
      q = neg_ff ? -52'(quo_ff) - 52'(rem_ff != '0) : 52'(quo_ff);
      r = q + (52'(k_ff) <<< 16);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else state_ff <= state_in;
      case (state_ff)
         BK_IDLE: begin
            out_ff <= {job_data.result, job_data.status};
            neg_ff <= job_data.num2 < 0;
            mag_ff <= job_data.num2 < 0 ? 51'(-job_data.num2) : 51'(job_data.num2);
            den_ff <= job_data.den2;
            k_ff <= job_data.k;
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         BK_DIV: begin
            if (!trial[34]) begin
               rem_ff <= trial[33:0];
               quo_ff <= {quo_ff[49:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[32:0], mag_ff[50]};
               quo_ff <= {quo_ff[49:0], 1'b0};
            end
            mag_ff <= {mag_ff[49:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
         end
         BK_FIX: begin
            if (r > 52'sd2147483647) begin
               out_ff <= {32'h7FFFFFFF, ST_SAT};
            end else if (r < -52'sd2147483648) begin
               out_ff <= {32'h80000000, ST_SAT};
            end else begin
               out_ff <= {r[31:0], ST_OK};
            end
         end
         default: ;
      endcase
   end
endmodule

// ===== hdl/peak_lattice_signal_normalizer.sv =====
// Peak lattice signal normalizer top level.
// Depends on plsn_pkg, plsn_front, plsn_queue, plsn_back and the macro header.
//
// Usage: req_* carries requests (load one peak level or normalize one sample),
// rsp_* returns exactly one result per request, in order. csr_we/csr_wdata write
// failure_value; write it only while the block is idle, which the block does not enforce.
// A load or a short-table normalize is registered in the front end, passes the
// queue, is loaded by the back end and shown on rsp_*. A full normalize first
// steps through the bracket search in the front end, then passes the queue, is
// loaded by the back end and runs the bit-serial divider and the fixup state.
// The back end takes a new job only once its last result is accepted (load, divide,
// fixup, output); loads and short-table requests pass only its load and output states.
// The two-entry job queue lets the front end accept loads while the divider runs.
// Reset (synchronous, active high) empties the peak table, queue and pipeline
// and clears failure_value. A stalled rsp_ready holds the result and backs up
// through the queue to req_ready.
`include "peak_lattice_signal_normalizer_macros.svh"
module peak_lattice_signal_normalizer
   import plsn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);
   logic [31:0] fail_ff;
   logic        f_valid, f_ready, b_valid, b_ready;
   job_type     f_job, b_job;

   always_ff @(posedge clock) begin
      if (reset) fail_ff <= '0;
      else if (csr_we) fail_ff <= csr_wdata;
   end

   plsn_front u_front (
      .clock, .reset, .csr_failure_value(fail_ff),
      .req_valid, .req_ready, .req_data,
      .job_valid(f_valid), .job_ready(f_ready), .job_data(f_job)
   );

   plsn_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_job)
   );

   plsn_back u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_ready(b_ready), .job_data(b_job),
      .rsp_valid, .rsp_ready, .rsp_data
   );

   `PLSN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped while stalled")
   `PLSN_ASSERT_IMPL(a_status_range, clock, reset, rsp_valid, rsp_data.status <= 3'(ST_SAT), "bad status code")
   `PLSN_ASSERT_IMPL(a_queue_hs, clock, reset, b_valid && b_ready, !rsp_valid, "back end took a job while holding a result")
endmodule
